// ===== design/idw_pkg.sv =====
// Package for the display I2C write master: request codes, item and result
// structs, sequencer phase encoding and the line levels for each phase.
// No dependencies.
package idw_pkg;

    localparam logic [7:0] ADDR_PRIMARY   = 8'h78;
    localparam logic [7:0] ADDR_ALTERNATE = 8'h7A;
    localparam logic [7:0] CTRL_COMMAND   = 8'h00;
    localparam logic [7:0] CTRL_DATA      = 8'h40;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_CMD   = 2'd1,
        FUNC_DATA  = 2'd2,
        FUNC_PROBE = 2'd3
    } t_func;

    typedef struct packed {
        t_func      func;
        logic [7:0] payload;
        logic       sda;
    } t_item;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
        logic nack;
        logic alt;
    } t_res;

    typedef enum logic [11:0] {
        PH_IDLE   = 12'b0000_0000_0001,
        PH_START1 = 12'b0000_0000_0010,
        PH_START2 = 12'b0000_0000_0100,
        PH_START3 = 12'b0000_0000_1000,
        PH_START4 = 12'b0000_0001_0000,
        PH_BIT_LO = 12'b0000_0010_0000,
        PH_BIT_HI = 12'b0000_0100_0000,
        PH_ACK_LO = 12'b0000_1000_0000,
        PH_ACK_HI = 12'b0001_0000_0000,
        PH_STOP1  = 12'b0010_0000_0000,
        PH_STOP2  = 12'b0100_0000_0000,
        PH_STOP3  = 12'b1000_0000_0000
    } t_phase;

    // {scl, sda} driven during a phase
    function automatic logic [1:0] line_levels(input t_phase phase, input logic bitv);
        logic [1:0] lv;
        case (phase)
            PH_START3: lv = 2'b10;
            PH_START4: lv = 2'b00;
            PH_BIT_LO: lv = {1'b0, bitv};
            PH_BIT_HI: lv = {1'b1, bitv};
            PH_ACK_LO: lv = 2'b01;
            PH_STOP1:  lv = 2'b00;
            PH_STOP2:  lv = 2'b10;
            default:   lv = 2'b11;
        endcase
        return lv;
    endfunction

endpackage

// ===== design/i2c_display_write_master.sv =====
// I2C display write master, one result per input item.
// A result is formed when the sequencer takes its item, then waits in the result queue until popped.
// Throughput: one item per cycle while the result queue has room, set by the single-step sequencer.
// Two-entry queues sit before and after the sequencer.
// Reset: synchronous active-low; clears both queues and returns the bus to idle
// with address 0x78 selected.
module i2c_display_write_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_func,
    input  logic [7:0] i_payload_byte,
    input  logic       i_sda_level,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl_level,
    output logic       o_sda_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_ack_missing,
    output logic       o_address_alternate
);
    import idw_pkg::*;

    t_item item;
    logic  item_valid;
    logic  take;
    t_res  res;
    t_res  res_out;
    logic  res_full;

    idw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_func         (i_func),
        .i_payload_byte (i_payload_byte),
        .i_sda_level    (i_sda_level),
        .o_full         (full),
        .i_take         (take),
        .o_valid        (item_valid),
        .o_item         (item)
    );

    idw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (item_valid),
        .i_item     (item),
        .i_res_full (res_full),
        .o_take     (take),
        .o_res      (res)
    );

    idw_fifo #(.WIDTH($bits(t_res))) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_scl_level         = res_out.scl;
    assign o_sda_drive         = res_out.sda;
    assign o_busy_res          = res_out.busy;
    assign o_done_res          = res_out.done;
    assign o_ack_missing       = res_out.nack;
    assign o_address_alternate = res_out.alt;

endmodule

// ===== design/idw_fifo.sv =====
// Two-entry queue with push/full and pop/empty sides.
// Used between the front end and the sequencer, and for results.
module idw_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/idw_front.sv =====
// Front end: takes input transactions, decodes the request code and queues
// the item for the sequencer. Depends on idw_pkg and idw_fifo.
module idw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [1:0]    i_func,
    input  logic [7:0]    i_payload_byte,
    input  logic          i_sda_level,
    output logic          o_full,
    input  logic          i_take,
    output logic          o_valid,
    output idw_pkg::t_item o_item
);
    import idw_pkg::*;

    t_item item_in;
    logic  empty;

    always_comb begin
        item_in.func    = t_func'(i_func);
        item_in.payload = i_payload_byte;
        // sampled level only matters on ticks
        item_in.sda     = (t_func'(i_func) == FUNC_TICK) ? i_sda_level : 1'b1;
    end

    idw_fifo #(.WIDTH($bits(t_item))) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (item_in),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (o_item),
        .o_empty (empty)
    );

    assign o_valid = !empty;

endmodule

// ===== design/idw_seq.sv =====
// Bus sequencer: one bus phase step per tick item, a request item starting a
// transfer when idle; produces the line levels and status for each item. Depends on idw_pkg.
module idw_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  idw_pkg::t_item i_item,
    input  logic           i_res_full,
    output logic           o_take,
    output idw_pkg::t_res  o_res
);
    import idw_pkg::*;

    t_phase     r_phase,  n_phase;
    t_func      r_kind,   n_kind;
    logic [1:0] r_byte,   n_byte;
    logic [2:0] r_bit,    n_bit;
    logic [7:0] r_shift,  n_shift;
    logic [7:0] r_held,   n_held;
    logic       r_nack,   n_nack;
    logic       r_alt,    n_alt;
    logic       r_second, n_second;
    logic       done;
    logic [1:0] lv;

    assign o_take = i_valid && !i_res_full;

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_byte   = r_byte;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_held   = r_held;
        n_nack   = r_nack;
        n_alt    = r_alt;
        n_second = r_second;
        done     = 1'b0;
        if (o_take) begin
            if (i_item.func == FUNC_TICK) begin
                case (r_phase)
                    PH_START1: n_phase = PH_START2;
                    PH_START2: n_phase = PH_START3;
                    PH_START3: n_phase = PH_START4;
                    PH_START4: begin
                        n_bit   = 3'd0;
                        n_phase = PH_BIT_LO;
                    end
                    PH_BIT_LO: n_phase = PH_BIT_HI;
                    PH_BIT_HI: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        if (r_bit == 3'd7) begin
                            n_phase = PH_ACK_LO;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_phase = PH_BIT_LO;
                        end
                    end
                    PH_ACK_LO: n_phase = PH_ACK_HI;
                    PH_ACK_HI: begin
                        if (i_item.sda) begin
                            n_nack = 1'b1;
                        end
                        if (r_kind == FUNC_PROBE) begin
                            // keep the alternate address only if it answered
                            if (!i_item.sda && r_second) begin
                                n_alt = 1'b1;
                            end
                            n_phase = PH_STOP1;
                        end else if (r_byte < 2'd2) begin
                            n_byte  = r_byte + 2'd1;
                            if (r_byte == 2'd0) begin
                                n_shift = (r_kind == FUNC_CMD) ? CTRL_COMMAND : CTRL_DATA;
                            end else begin
                                n_shift = r_held;
                            end
                            n_bit   = 3'd0;
                            n_phase = PH_BIT_LO;
                        end else begin
                            n_phase = PH_STOP1;
                        end
                    end
                    PH_STOP1: n_phase = PH_STOP2;
                    PH_STOP2: n_phase = PH_STOP3;
                    PH_STOP3: begin
                        if (r_kind == FUNC_PROBE && !r_second && r_nack) begin
                            // retry the probe at the alternate address
                            n_second = 1'b1;
                            n_nack   = 1'b0;
                            n_shift  = ADDR_ALTERNATE;
                            n_byte   = 2'd0;
                            n_bit    = 3'd0;
                            n_phase  = PH_START1;
                        end else begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end else if (r_phase == PH_IDLE) begin
                n_kind   = i_item.func;
                n_held   = i_item.payload;
                n_nack   = 1'b0;
                n_second = 1'b0;
                n_byte   = 2'd0;
                n_bit    = 3'd0;
                if (i_item.func == FUNC_PROBE) begin
                    n_alt   = 1'b0;
                    n_shift = ADDR_PRIMARY;
                end else begin
                    n_shift = r_alt ? ADDR_ALTERNATE : ADDR_PRIMARY;
                end
                n_phase  = PH_START1;
            end
        end
    end

    always_comb begin
        lv         = line_levels(n_phase, n_shift[7]);
        o_res.scl  = lv[1];
        o_res.sda  = lv[0];
        o_res.busy = (n_phase != PH_IDLE);
        o_res.done = done;
        o_res.nack = n_nack;
        o_res.alt  = n_alt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_kind   <= FUNC_TICK;
            r_byte   <= 2'd0;
            r_bit    <= 3'd0;
            r_shift  <= 8'd0;
            r_held   <= 8'd0;
            r_nack   <= 1'b0;
            r_alt    <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_byte   <= n_byte;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_held   <= n_held;
            r_nack   <= n_nack;
            r_alt    <= n_alt;
            r_second <= n_second;
        end
    end

endmodule

// ===== design/idw_chk.sv =====
// Port-level checks for the display I2C write master, and the bind that
// attaches them to the top level. Depends on i2c_display_write_master.
module idw_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_scl_level,
    input logic       o_sda_drive,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic       o_ack_missing,
    input logic       o_address_alternate
);

    // queues come up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // a finished transaction leaves the bus idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    // idle bus has both lines released
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_busy_res |-> o_scl_level && o_sda_drive)
        else $error("lines driven while idle");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped without pop");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable({o_scl_level, o_sda_drive, o_busy_res, o_done_res,
                                    o_ack_missing, o_address_alternate}))
        else $error("stalled result changed");

endmodule

bind i2c_display_write_master idw_chk u_chk (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for i2c_display_write_master: random and directed
// bus requests with queue-side stalls, checked against an in-bench sequencer model.
// Depends on idw_pkg and the i2c_display_write_master RTL.
`timescale 1ns / 100ps

module tb_top;
    import idw_pkg::*;

    localparam int TICKS_WRITE  = 61;
    localparam int TICKS_PROBE  = 50;
    localparam int ACK_TICK_ADDR = 22;   // address byte / first probe attempt
    localparam int ACK_TICK_CTRL = 40;   // control byte of a write
    localparam int ACK_TICK_ALT  = 47;   // second probe attempt
    localparam int RANDOM_ITEMS = 1600;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 10;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_START1, SEQ_START2, SEQ_START3, SEQ_START4,
        SEQ_BIT_LO, SEQ_BIT_HI, SEQ_ACK_LO, SEQ_ACK_HI,
        SEQ_STOP1, SEQ_STOP2, SEQ_STOP3
    } t_seq_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [1:0] i_func;
    logic [7:0] i_payload_byte;
    logic       i_sda_level;
    logic       empty;
    logic       pop;
    logic       o_scl_level;
    logic       o_sda_drive;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_ack_missing;
    logic       o_address_alternate;

    i2c_display_write_master dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_func              (i_func),
        .i_payload_byte      (i_payload_byte),
        .i_sda_level         (i_sda_level),
        .empty               (empty),
        .pop                 (pop),
        .o_scl_level         (o_scl_level),
        .o_sda_drive         (o_sda_drive),
        .o_busy_res          (o_busy_res),
        .o_done_res          (o_done_res),
        .o_ack_missing       (o_ack_missing),
        .o_address_alternate (o_address_alternate)
    );

    always #1 i_clk = ~i_clk;

    // Sequencer model state
    t_seq_phase seq_phase;
    t_func      seq_kind;
    logic [1:0] seq_byte_idx;
    logic [2:0] seq_bit_idx;
    logic [7:0] seq_shift;
    logic [7:0] seq_payload;
    logic       seq_nack;
    logic       seq_alt;
    logic       seq_second_try;

    t_item bus_requests[$];
    t_res  expected_levels[$];
    t_item active_req;
    int    src_gap, snk_gap;
    logic  src_steady, snk_steady;
    int    mismatches;
    int    stalled_cycles;

    task automatic reset_sequencer();
        seq_phase      = SEQ_IDLE;
        seq_kind       = FUNC_TICK;
        seq_byte_idx   = '0;
        seq_bit_idx    = '0;
        seq_shift      = '0;
        seq_payload    = '0;
        seq_nack       = 1'b0;
        seq_alt        = 1'b0;
        seq_second_try = 1'b0;
    endtask

    // Apply one accepted item and return the line levels and flags it yields.
    task automatic step_sequencer(input t_item it, output t_res r);
        logic finished;
        logic acked;
        logic bitv;
        finished = 1'b0;
        acked    = !it.sda;
        if (it.func == FUNC_TICK) begin
            case (seq_phase)
                SEQ_IDLE:   ;
                SEQ_START1: seq_phase = SEQ_START2;
                SEQ_START2: seq_phase = SEQ_START3;
                SEQ_START3: seq_phase = SEQ_START4;
                SEQ_START4: begin
                    seq_bit_idx = '0;
                    seq_phase   = SEQ_BIT_LO;
                end
                SEQ_BIT_LO: seq_phase = SEQ_BIT_HI;
                SEQ_BIT_HI: begin
                    seq_shift = seq_shift << 1;
                    if (seq_bit_idx == 3'd7) begin
                        seq_phase = SEQ_ACK_LO;
                    end else begin
                        seq_bit_idx++;
                        seq_phase = SEQ_BIT_LO;
                    end
                end
                SEQ_ACK_LO: seq_phase = SEQ_ACK_HI;
                SEQ_ACK_HI: begin
                    if (!acked) begin
                        seq_nack = 1'b1;
                    end else if (seq_kind == FUNC_PROBE && seq_second_try) begin
                        seq_alt = 1'b1;
                    end
                    if (seq_kind != FUNC_PROBE && seq_byte_idx < 2'd2) begin
                        // move on to the control byte, then the payload
                        if (seq_byte_idx == 2'd0) begin
                            seq_shift = (seq_kind == FUNC_CMD) ? CTRL_COMMAND : CTRL_DATA;
                        end else begin
                            seq_shift = seq_payload;
                        end
                        seq_byte_idx++;
                        seq_bit_idx = '0;
                        seq_phase   = SEQ_BIT_LO;
                    end else begin
                        seq_phase = SEQ_STOP1;
                    end
                end
                SEQ_STOP1: seq_phase = SEQ_STOP2;
                SEQ_STOP2: seq_phase = SEQ_STOP3;
                SEQ_STOP3: begin
                    if (seq_kind == FUNC_PROBE && !seq_second_try && seq_nack) begin
                        // retry the probe at the alternate address
                        seq_second_try = 1'b1;
                        seq_nack       = 1'b0;
                        seq_shift      = ADDR_ALTERNATE;
                        seq_byte_idx   = '0;
                        seq_bit_idx    = '0;
                        seq_phase      = SEQ_START1;
                    end else begin
                        seq_phase = SEQ_IDLE;
                        finished  = 1'b1;
                    end
                end
                default: seq_phase = SEQ_IDLE;
            endcase
        end else if (seq_phase == SEQ_IDLE) begin
            seq_kind       = it.func;
            seq_payload    = it.payload;
            seq_nack       = 1'b0;
            seq_second_try = 1'b0;
            seq_byte_idx   = '0;
            seq_bit_idx    = '0;
            if (it.func == FUNC_PROBE) begin
                seq_alt = 1'b0;
            end
            seq_shift = (it.func == FUNC_PROBE || !seq_alt) ? ADDR_PRIMARY : ADDR_ALTERNATE;
            seq_phase = SEQ_START1;
        end

        bitv = seq_shift[7];
        case (seq_phase)
            SEQ_START3: {r.scl, r.sda} = 2'b10;
            SEQ_START4: {r.scl, r.sda} = 2'b00;
            SEQ_BIT_LO: {r.scl, r.sda} = {1'b0, bitv};
            SEQ_BIT_HI: {r.scl, r.sda} = {1'b1, bitv};
            SEQ_ACK_LO: {r.scl, r.sda} = 2'b01;
            SEQ_STOP1:  {r.scl, r.sda} = 2'b00;
            SEQ_STOP2:  {r.scl, r.sda} = 2'b10;
            default:    {r.scl, r.sda} = 2'b11;
        endcase
        r.busy = (seq_phase != SEQ_IDLE);
        r.done = finished;
        r.nack = seq_nack;
        r.alt  = seq_alt;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_item(input t_func f, input logic [7:0] data, input logic sda);
        bus_requests.push_back(t_item'({f, data, sda}));
    endtask

    // One request followed by its ticks; nack_tick forces SDA high on one tick.
    task automatic add_transfer(input t_func kind, input logic [7:0] data,
                                input int nack_pct, input int nack_tick,
                                input int n_ticks, input int noise_pct);
        add_item(kind, data, 1'($urandom_range(0, 1)));
        for (int k = 1; k <= n_ticks; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                add_item(t_func'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end
            add_item(FUNC_TICK, 8'($urandom_range(0, 255)),
                     (k == nack_tick) || ($urandom_range(0, 99) < nack_pct));
        end
    endtask

    // Request side: present the next queued item, hold it until accepted.
    always @(posedge i_clk) begin : drive_requests
        t_res predicted;
        logic push_next;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            push_next = push;
            if (push && !full) begin
                step_sequencer(active_req, predicted);
                expected_levels.push_back(predicted);
                push_next = 1'b0;
                if ($urandom_range(0, 149) == 0) src_steady = !src_steady;
            end
            if (!push_next) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (bus_requests.size() > 0) begin
                    active_req = bus_requests.pop_front();
                    i_func         <= active_req.func;
                    i_payload_byte <= active_req.payload;
                    i_sda_level    <= active_req.sda;
                    push_next = 1'b1;
                    src_gap   = src_steady ? 0 : pick_gap();
                end
            end
            push <= push_next;
        end
    end

    // Result side: pop with random stalls and compare against the model.
    always @(posedge i_clk) begin : check_levels
        t_res seen;
        t_res want;
        logic pop_next;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                seen = {o_scl_level, o_sda_drive, o_busy_res, o_done_res,
                        o_ack_missing, o_address_alternate};
                if (expected_levels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: unexpected result scl=%b sda=%b busy=%b done=%b nack=%b alt=%b",
                                 $realtime, seen.scl, seen.sda, seen.busy, seen.done,
                                 seen.nack, seen.alt);
                    end
                end else begin
                    want = expected_levels.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: mismatch exp scl=%b sda=%b busy=%b done=%b nack=%b alt=%b",
                                     $realtime, want.scl, want.sda, want.busy, want.done,
                                     want.nack, want.alt);
                            $display("%0t:          got scl=%b sda=%b busy=%b done=%b nack=%b alt=%b",
                                     $realtime, seen.scl, seen.sda, seen.busy, seen.done,
                                     seen.nack, seen.alt);
                        end
                    end
                end
                if ($urandom_range(0, 149) == 0) snk_steady = !snk_steady;
                snk_gap = snk_steady ? 0 : pick_gap();
            end
            if (snk_gap > 0) begin
                snk_gap--;
                pop_next = 1'b0;
            end else begin
                pop_next = 1'b1;
            end
            pop <= pop_next;
        end
    end

    // Abort when neither side has moved a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("i2c_display_write_master regression: fail");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        i_func         = FUNC_TICK;
        i_payload_byte = '0;
        i_sda_level    = 1'b1;
        src_gap        = 0;
        snk_gap        = 0;
        src_steady     = 1'b0;
        snk_steady     = 1'b0;
        mismatches     = 0;
        stalled_cycles = 0;
        reset_sequencer();

        // Directed: idle ticks, payload extremes, every request kind,
        // nack paths, probe fallback to the alternate address, busy requests.
        add_item(FUNC_TICK, 8'h00, 1'b0);
        add_item(FUNC_TICK, 8'hFF, 1'b1);
        add_transfer(FUNC_CMD,   8'hFF, 0,   0,             TICKS_WRITE, 0);
        add_transfer(FUNC_DATA,  8'h00, 100, 0,             TICKS_WRITE, 0);
        add_transfer(FUNC_CMD,   8'hA5, 0,   ACK_TICK_CTRL, TICKS_WRITE, 0);
        add_transfer(FUNC_PROBE, 8'h00, 0,   ACK_TICK_ADDR, TICKS_PROBE, 0);
        add_transfer(FUNC_DATA,  8'h5A, 0,   0,             TICKS_WRITE, 0);
        add_transfer(FUNC_PROBE, 8'hFF, 0,   0,             TICKS_PROBE, 0);
        add_transfer(FUNC_PROBE, 8'h3C, 100, 0,             TICKS_PROBE, 0);
        add_transfer(FUNC_PROBE, 8'hC3, 0,   ACK_TICK_ALT,  TICKS_PROBE, 0);
        add_transfer(FUNC_CMD,   8'h81, 0,   0,             TICKS_WRITE, 20);

        // Random: mostly complete transfers, some cut short, some noise.
        while (bus_requests.size() < RANDOM_ITEMS) begin
            int pick;
            int pct;
            t_func kind;
            pick = $urandom_range(0, 99);
            kind = t_func'($urandom_range(1, 3));
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 5;
                2:       pct = 30;
                default: pct = 60;
            endcase
            if (pick < 85) begin
                add_transfer(kind, 8'($urandom_range(0, 255)), pct, 0,
                             (kind == FUNC_PROBE) ? TICKS_PROBE : TICKS_WRITE,
                             ($urandom_range(0, 3) == 0) ? 5 : 0);
                repeat ($urandom_range(0, 2)) add_item(FUNC_TICK, 8'($urandom_range(0, 255)),
                                                       1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                add_transfer(kind, 8'($urandom_range(0, 255)), pct, 0,
                             $urandom_range(1, TICKS_WRITE - 1), 0);
            end else begin
                repeat ($urandom_range(1, 5)) add_item(t_func'($urandom_range(0, 3)),
                                                       8'($urandom_range(0, 255)),
                                                       1'($urandom_range(0, 1)));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bus_requests.size() != 0 || push || expected_levels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_levels.size() == 0) begin
            $display("i2c_display_write_master regression: pass");
        end else begin
            $display("i2c_display_write_master regression: fail");
        end
        $finish;
    end

endmodule
